// ===== src/sae_pkg.sv =====
package sae_pkg;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int SIZE_W    = 16;
  localparam int ALIGN_W   = 4;
  localparam int ADDR_W    = 32;
  localparam int OFF_W     = 13;
  localparam int PAD_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // Parameter defaults
  localparam int ARENA_BYTES_DEF    = 4096;
  localparam int HEADER_BYTES_DEF   = 1;
  localparam int MAX_ALIGN_LOG2_DEF = 7;

  localparam logic [OFF_W-1:0] LENGTH_RESET = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA_BASE   = 1'd0,
    CFG_ARENA_LENGTH = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic pad_read;
    logic commit_direct;
    logic commit_free;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_pad;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== src/sae_if.sv =====
interface sae_in_if;
  logic                         valid;
  logic                         ready;
  logic [sae_pkg::CMD_W-1:0]    command;
  logic [sae_pkg::SIZE_W-1:0]   request_size;
  logic [sae_pkg::SIZE_W-1:0]   current_size;
  logic [sae_pkg::ALIGN_W-1:0]  align_log2;
  logic [sae_pkg::ADDR_W-1:0]   block_address;
  logic                         address_present;

  modport source (output valid, command, request_size, current_size, align_log2,
                  block_address, address_present, input ready);
  modport sink (input valid, command, request_size, current_size, align_log2,
                block_address, address_present, output ready);
endinterface

interface sae_out_if;
  logic                          valid;
  logic                          ready;
  logic [sae_pkg::STATUS_W-1:0]  status;
  logic [sae_pkg::ADDR_W-1:0]    result_address;
  logic [sae_pkg::SIZE_W-1:0]    copy_length;
  logic [sae_pkg::OFF_W-1:0]     used_bytes;

  modport source (output valid, status, result_address, copy_length, used_bytes,
                  input ready);
  modport sink (input valid, status, result_address, copy_length, used_bytes,
                output ready);
endinterface

// ===== src/stack_allocator_engine.sv =====
// Channel  | Dir | Handshake      | Word
// ---------+-----+----------------+---------------------------------------------
// in_ch    | in  | valid / ready  | command, sizes, align_log2, address, present
// out_ch   | out | valid / ready  | status, result_address, copy_length, used
// cfg      | in  | cfg_we         | cfg_index, cfg_data (arena base, length)
//
// Allocate, clear, resize and null or failed free pass through accept, then
// execute and commit. A free that reaches the pad store adds the pad stage
// for the registered read of the pad RAM that sets the new top.
// After reset a clearing pass zeroes every entry of the pad store with
// in_ch.ready low; configuration writes are taken during it.
// A stalled out_ch holds the finished word; the next word is accepted into the
// input register and waits in execute, or in the pad stage for a free, until
// the output register frees.
module stack_allocator_engine #(
  parameter int ARENA_BYTES    = sae_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES   = sae_pkg::HEADER_BYTES_DEF,
  parameter int MAX_ALIGN_LOG2 = sae_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sae_in_if.sink                        in_ch,
  sae_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sae_pkg::CFG_W-1:0]     cfg_data
);

  // Command and status between controller and datapath
  sae_pkg::ctrl_cmd_t cmd;
  sae_pkg::dp_stat_t  stat;
  logic               in_ready;
  logic               out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Sequence accept, execute, pad read, commit and the clearing pass
  sae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the arena registers, top offset, pad store and output register
  sae_dp #(
    .ARENA_BYTES    (ARENA_BYTES),
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (in_ch.command),
    .request_size    (in_ch.request_size),
    .current_size    (in_ch.current_size),
    .align_log2      (in_ch.align_log2),
    .block_address   (in_ch.block_address),
    .address_present (in_ch.address_present),
    .status          (out_ch.status),
    .result_address  (out_ch.result_address),
    .copy_length     (out_ch.copy_length),
    .used_bytes      (out_ch.used_bytes)
  );

endmodule

// ===== src/sae_ram.sv =====
module sae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sae_ctrl.sv =====
module sae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sae_pkg::dp_stat_t   stat,
  output sae_pkg::ctrl_cmd_t  cmd
);

  sae_pkg::state_t state, state_next;
  logic            out_free;
  logic            out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sae_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sae_pkg::S_CLEAR: if (stat.clr_last) state_next = sae_pkg::S_IDLE;
      sae_pkg::S_IDLE:  if (in_valid) state_next = sae_pkg::S_EXEC;
      sae_pkg::S_EXEC: begin
        if (stat.needs_pad) begin
          state_next = sae_pkg::S_PAD;
        end else if (out_free) begin
          state_next = sae_pkg::S_IDLE;
        end
      end
      sae_pkg::S_PAD:   if (out_free) state_next = sae_pkg::S_IDLE;
      default:          state_next = sae_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd               = '0;
    in_ready          = 1'b0;
    unique case (state)
      sae_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      sae_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      sae_pkg::S_EXEC: begin
        cmd.pad_read      = stat.needs_pad;
        cmd.commit_direct = !stat.needs_pad && out_free;
      end
      sae_pkg::S_PAD:   cmd.commit_free = out_free;
      default:          cmd = '0;
    endcase
    if (cmd.commit_direct || cmd.commit_free) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // A word is never overwritten while it waits downstream
  a_commit_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_direct || cmd.commit_free) |-> (!out_valid || out_ready))
    else $error("commit while output word is held");

  // A pad read is always followed by the pad stage
  a_pad_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.pad_read |=> (state == sae_pkg::S_PAD))
    else $error("pad read not followed by pad stage");

  // A new output word appears only right after a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit_direct || cmd.commit_free))
    else $error("output word without commit");

  // No input is taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == sae_pkg::S_CLEAR) |-> !in_ready)
    else $error("input accepted during clear sweep");

endmodule

// ===== src/sae_dp.sv =====
module sae_dp #(
  parameter int ARENA_BYTES    = sae_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES   = sae_pkg::HEADER_BYTES_DEF,
  parameter int MAX_ALIGN_LOG2 = sae_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sae_pkg::ctrl_cmd_t            cmd,
  output sae_pkg::dp_stat_t             stat,
  // configuration
  input  logic                          cfg_we,
  input  logic [sae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sae_pkg::CFG_W-1:0]     cfg_data,
  // input word fields
  input  logic [sae_pkg::CMD_W-1:0]     command,
  input  logic [sae_pkg::SIZE_W-1:0]    request_size,
  input  logic [sae_pkg::SIZE_W-1:0]    current_size,
  input  logic [sae_pkg::ALIGN_W-1:0]   align_log2,
  input  logic [sae_pkg::ADDR_W-1:0]    block_address,
  input  logic                          address_present,
  // output word fields
  output logic [sae_pkg::STATUS_W-1:0]  status,
  output logic [sae_pkg::ADDR_W-1:0]    result_address,
  output logic [sae_pkg::SIZE_W-1:0]    copy_length,
  output logic [sae_pkg::OFF_W-1:0]     used_bytes
);

  localparam int OW = sae_pkg::OFF_W;
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int XW = (AW > OW) ? AW : OW;
  localparam logic [16:0]   ARENA_L  = 17'(ARENA_BYTES);
  localparam logic [OW-1:0] HDR      = OW'(HEADER_BYTES);
  localparam logic [8:0]    HDR9     = 9'(HEADER_BYTES);
  localparam logic [2:0]    MAX_LG   = 3'(MAX_ALIGN_LOG2);
  localparam logic [AW-1:0] LAST_IDX = AW'(ARENA_BYTES - 1);

  // Configuration registers
  logic [sae_pkg::ADDR_W-1:0] arena_base;
  logic [OW-1:0]              arena_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base   <= '0;
      arena_length <= sae_pkg::LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (sae_pkg::cfg_idx_t'(cfg_index))
        sae_pkg::CFG_ARENA_BASE:   arena_base   <= cfg_data;
        sae_pkg::CFG_ARENA_LENGTH: arena_length <= cfg_data[OW-1:0];
        default:                   arena_base   <= arena_base;
      endcase
    end
  end

  // Held input word
  sae_pkg::cmd_t               cmd_q;
  logic [sae_pkg::SIZE_W-1:0]  req_q, old_q;
  logic [sae_pkg::ALIGN_W-1:0] lg_q;
  logic [sae_pkg::ADDR_W-1:0]  addr_q;
  logic                        present_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q     <= sae_pkg::cmd_t'(command);
      req_q     <= request_size;
      old_q     <= current_size;
      lg_q      <= align_log2;
      addr_q    <= block_address;
      present_q <= address_present;
    end
  end

  logic [OW-1:0] top, top_next;
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign stat.clr_last = (clr_cnt == LAST_IDX);

  // Effective arena length
  logic [OW-1:0] eff_len;
  assign eff_len = ({4'd0, arena_length} < ARENA_L) ? arena_length : ARENA_L[OW-1:0];

  // Alignment and pad
  logic [2:0]    lg_eff;
  logic [8:0]    align, mask;
  logic [7:0]    cur_lo, modv;
  logic [8:0]    pad0, need, pad_add, pad;
  logic [17:0]   alloc_end;
  logic          fits;
  logic [OW-1:0] alloc_next, alloc_top, widx13;
  logic [sae_pkg::ADDR_W-1:0] alloc_addr;

  assign lg_eff = ({1'b0, lg_q} > {1'b0, MAX_LG}) ? MAX_LG : lg_q[2:0];
  assign align  = 9'd1 << lg_eff;
  assign mask   = align - 9'd1;
  assign cur_lo = arena_base[7:0] + top[7:0];
  assign modv   = cur_lo & mask[7:0];

  always_comb begin
    pad0    = (modv != 8'd0) ? (align - {1'b0, modv}) : 9'd0;
    need    = HDR9 - pad0;
    pad_add = (need + mask) & ~mask;
    pad     = (pad0 < HDR9) ? (pad0 + pad_add) : pad0;
  end

  assign alloc_end  = 18'(top) + 18'(pad) + 18'(req_q);
  assign fits       = (alloc_end <= 18'(eff_len));
  assign alloc_next = top + OW'(pad);
  assign alloc_top  = alloc_next + req_q[OW-1:0];
  assign alloc_addr = arena_base + sae_pkg::ADDR_W'(alloc_next);
  assign widx13     = alloc_next - HDR;

  // Address check
  logic [sae_pkg::ADDR_W:0]   arena_end;
  logic [sae_pkg::ADDR_W-1:0] off32;
  logic [OW-1:0]              off, ridx13;
  logic                       out_range, stale, chk_ok, below_hdr;
  sae_pkg::status_t           chk_st;

  assign arena_end = {1'b0, arena_base} + (sae_pkg::ADDR_W + 1)'(eff_len);
  assign out_range = (addr_q < arena_base) || ({1'b0, addr_q} >= arena_end);
  assign off32     = addr_q - arena_base;
  assign off       = off32[OW-1:0];
  assign stale     = (off >= top);
  assign chk_st    = out_range ? sae_pkg::ST_RANGE :
                     stale     ? sae_pkg::ST_STALE : sae_pkg::ST_OK;
  assign chk_ok    = (chk_st == sae_pkg::ST_OK);
  assign below_hdr = (off < HDR);
  assign ridx13    = off - HDR;

  // Command decode
  logic is_resize, free_path, alloc_path, keep_path, resize_chk;

  assign is_resize  = (cmd_q == sae_pkg::CMD_RESIZE);
  assign resize_chk = is_resize && present_q && (req_q != '0);
  assign free_path  = ((cmd_q == sae_pkg::CMD_FREE) && present_q)
                   || (is_resize && present_q && (req_q == '0));
  assign alloc_path = (cmd_q == sae_pkg::CMD_ALLOC) || (is_resize && !present_q)
                   || (resize_chk && chk_ok && (old_q != req_q));
  assign keep_path  = resize_chk && chk_ok && (old_q == req_q);

  assign stat.needs_pad = free_path && chk_ok && !below_hdr;

  // Pad store
  logic [XW-1:0]        widx_x, ridx_x;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata, pad_rd;

  assign widx_x    = XW'(widx13);
  assign ridx_x    = XW'(ridx13);
  assign ram_we    = cmd.clr_step || (cmd.commit_direct && alloc_path && fits);
  assign ram_waddr = cmd.clr_step ? clr_cnt : widx_x[AW-1:0];
  assign ram_wdata = cmd.clr_step ? 8'd0 : pad[7:0];

  sae_ram #(
    .WIDTH (sae_pkg::PAD_W),
    .DEPTH (ARENA_BYTES)
  ) u_pad_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.pad_read),
    .raddr (ridx_x[AW-1:0]),
    .rdata (pad_rd)
  );

  // Result selection
  sae_pkg::status_t           st_sel;
  logic [sae_pkg::ADDR_W-1:0] res_sel;
  logic [sae_pkg::SIZE_W-1:0] copy_sel;
  logic                       pad_ok;

  assign pad_ok = ({5'd0, pad_rd} <= off);

  always_comb begin
    st_sel   = sae_pkg::ST_OK;
    res_sel  = '0;
    copy_sel = '0;
    top_next = top;
    if (cmd.commit_free) begin
      if (pad_ok) begin
        top_next = off - {5'd0, pad_rd};
      end else begin
        st_sel = sae_pkg::ST_RANGE;
      end
    end else begin
      priority if (free_path) begin
        st_sel = chk_ok ? sae_pkg::ST_RANGE : chk_st;
      end else if (alloc_path) begin
        if (fits) begin
          res_sel  = alloc_addr;
          top_next = alloc_top;
          // Only a moving resize of a live block leaves data to copy
          if (resize_chk) begin
            copy_sel = (old_q < req_q) ? old_q : req_q;
          end
        end else begin
          st_sel = sae_pkg::ST_OOM;
        end
      end else if (keep_path) begin
        res_sel = addr_q;
      end else if (resize_chk) begin
        st_sel = chk_st;
      end else if (cmd_q == sae_pkg::CMD_CLEAR) begin
        top_next = '0;
      end else begin
        st_sel = sae_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (cmd.commit_direct || cmd.commit_free) begin
      top <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_direct || cmd.commit_free) begin
      status         <= st_sel;
      result_address <= res_sel;
      copy_length    <= copy_sel;
      used_bytes     <= top_next;
    end
  end

endmodule
